FILE: hdl/bcdl_pkg.sv
// ----------------------------------------------------------------------------
// bcdl_pkg
// Shared widths, register indexes and gesture codes for the button gesture
// classifier.
// ----------------------------------------------------------------------------
package bcdl_pkg;

    localparam int LIMIT_W   = 16;
    localparam int GESTURE_W = 3;
    localparam int CFG_IDX_W = 1;

    typedef logic [LIMIT_W-1:0]   limit_t;
    typedef logic [GESTURE_W-1:0] gesture_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t CFG_LONG_LIMIT = 1'd0;
    localparam cfg_idx_t CFG_GAP_LIMIT  = 1'd1;

    localparam limit_t LONG_LIMIT_RST = 16'd400;
    localparam limit_t GAP_LIMIT_RST  = 16'd100;

    // gesture codes
    localparam gesture_t GEST_NONE   = 3'd0;
    localparam gesture_t GEST_CLICK  = 3'd1;
    localparam gesture_t GEST_DOUBLE = 3'd2;
    localparam gesture_t GEST_LONG1  = 3'd3;
    localparam gesture_t GEST_LONG2  = 3'd4;

endpackage

FILE: hdl/bcdl_core.sv
// ----------------------------------------------------------------------------
// bcdl_core
// Gesture state machine and saturating tick counter. Advances one step for
// each accepted button sample; gesture reflects the current phase.
// ----------------------------------------------------------------------------
module bcdl_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pressed,
    input  bcdl_pkg::limit_t  long_limit,
    input  bcdl_pkg::limit_t  gap_limit,
    output bcdl_pkg::gesture_t gesture
);
    import bcdl_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_PRESS1  = 4'd1,
        PH_GAP1    = 4'd2,
        PH_PRESS2  = 4'd3,
        PH_GAP2    = 4'd4,
        PH_WAIT    = 4'd5,
        PH_REP_CLK = 4'd6,
        PH_REP_DBL = 4'd7,
        PH_REP_L1  = 4'd8,
        PH_REP_L2  = 4'd9
    } phase_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    phase_t phase_reg, phase_next;
    count_t count_reg, count_next;
    count_t count_inc;
    logic   over_long;
    logic   over_gap;

    // saturate at all ones
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign over_long = CMP_W'(count_inc) > CMP_W'(long_limit);
    assign over_gap  = CMP_W'(count_inc) > CMP_W'(gap_limit);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_PRESS1;
                    count_next = '0;
                end
            end
            PH_PRESS1:
            begin
                // release clears the count, so the long test cannot fire then
                if (!pressed)
                begin
                    count_next = '0;
                    phase_next = PH_GAP1;
                end
                else
                begin
                    count_next = count_inc;
                    if (over_long)
                        phase_next = PH_REP_L1;
                end
            end
            PH_GAP1:
            begin
                count_next = count_inc;
                // timeout beats a new press on the same tick
                if (over_gap)
                    phase_next = PH_REP_CLK;
                else if (pressed)
                    phase_next = PH_PRESS2;
            end
            PH_PRESS2:
            begin
                if (!pressed)
                begin
                    count_next = '0;
                    phase_next = PH_GAP2;
                end
                else
                begin
                    count_next = count_inc;
                    if (over_long)
                        phase_next = PH_REP_L2;
                end
            end
            PH_GAP2:
            begin
                count_next = count_inc;
                if (over_gap)
                    phase_next = PH_REP_DBL;
            end
            PH_REP_CLK, PH_REP_DBL, PH_REP_L1, PH_REP_L2:
                phase_next = PH_WAIT;
            PH_WAIT:
            begin
                if (!pressed)
                    phase_next = PH_IDLE;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_REP_CLK: gesture = GEST_CLICK;
            PH_REP_DBL: gesture = GEST_DOUBLE;
            PH_REP_L1:  gesture = GEST_LONG1;
            PH_REP_L2:  gesture = GEST_LONG2;
            default:    gesture = GEST_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/button_click_double_long_classifier.sv
// ----------------------------------------------------------------------------
// button_click_double_long_classifier
// Classifies a stream of sampled button levels into click, double click,
// long press and long second press gestures, one code per sample.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   tvalid/tready       tdata[0] pressed
//  m_*       out  tvalid/tready       tdata[2:0] gesture
//  cfg_*     in   cfg_we              cfg_addr index, cfg_wdata value
//
//  One sample per cycle if s_tready is high; its word is valid the next cycle.
//  The output register holds a word until taken; s_tready is high whenever
//  that register is empty or being drained in the same cycle.
//  Reset clears the phase, the tick counter, the output valid and loads the
//  limit registers with 400 and 100.
// ----------------------------------------------------------------------------
module button_click_double_long_classifier #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] pressed
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [2:0] gesture
    input  logic                      cfg_we,
    input  bcdl_pkg::cfg_idx_t        cfg_addr,
    input  bcdl_pkg::limit_t          cfg_wdata
);
    import bcdl_pkg::*;

    limit_t   long_limit_reg;
    limit_t   gap_limit_reg;
    logic     out_valid_reg, out_valid_next;
    gesture_t gesture_reg;
    gesture_t core_gesture;
    logic     step;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    bcdl_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pressed    (s_tdata[0]),
        .long_limit (long_limit_reg),
        .gap_limit  (gap_limit_reg),
        .gesture    (core_gesture)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_limit_reg <= LONG_LIMIT_RST;
            gap_limit_reg  <= GAP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_LONG_LIMIT: long_limit_reg <= cfg_wdata;
                CFG_GAP_LIMIT:  gap_limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // load the word for the accepted sample
    always_ff @(posedge clk)
    begin
        if (step)
            gesture_reg <= core_gesture;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - GESTURE_W){1'b0}}, gesture_reg};

`ifndef ASSERT_OFF
    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("accepted sample did not produce an output word");

    a_report_once: assert property (@(posedge clk) disable iff (!rst_n)
        (step && core_gesture != GEST_NONE) |=> core_gesture == GEST_NONE)
        else $error("gesture reported on two consecutive samples");

    a_gesture_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (gesture_reg == GEST_NONE || gesture_reg == GEST_CLICK
            || gesture_reg == GEST_DOUBLE || gesture_reg == GEST_LONG1
            || gesture_reg == GEST_LONG2))
        else $error("gesture code out of range");
`endif

endmodule
